FILE: design/tsdc_pkg.sv
`timescale 1ns / 1ps

package tsdc_pkg;

  // Default number of valid readings that make up one average.
  localparam int unsigned SAMPLES_AVERAGED_DEF = 8;

  // Both data-ready bits of the status byte must be set for a reading to count.
  localparam logic [7:0] STATUS_VALID_MASK = 8'h03;

  // Pulse widths in timer counts.
  localparam int unsigned PULSE_NEUTRAL = 2769;
  localparam int unsigned DRIVE_MIN     = 2030;
  localparam int unsigned DRIVE_MAX     = 3507;
  localparam int unsigned STEER_RIGHT   = 3329;
  localparam int unsigned STEER_LEFT    = 1909;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEER_GAIN       = 2'd0;
  localparam logic [1:0] CFG_ROLL_SPEED_GAIN  = 2'd1;
  localparam logic [1:0] CFG_PITCH_SPEED_GAIN = 2'd2;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_STOPPED = 2'd2
  } dir_e;

  typedef struct packed {
    logic [7:0]         status_byte;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] x_average;
    logic signed [11:0] y_average;
    logic [11:0]        servo_pulse;
    logic [11:0]        drive_pulse;
    dir_e               direction;
  } out_item_t;

  typedef struct packed {
    logic [3:0] steer_gain;
    logic [5:0] roll_speed_gain;
    logic [5:0] pitch_speed_gain;
  } gain_cfg_t;

endpackage

FILE: design/tsdc_front.sv
`timescale 1ns / 1ps

module tsdc_front import tsdc_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF,
  localparam int unsigned SumW = 12 + $clog2(SAMPLES_AVERAGED)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  input  logic            q_full_i,
  output logic            push_o,
  output logic [SumW-1:0] x_sum_o,
  output logic [SumW-1:0] y_sum_o
);

  localparam int unsigned CntW = $clog2(SAMPLES_AVERAGED);
  // The sums start at 2048 times the sample count, so that they stay
  // non-negative and the finished sum is already offset for the divider.
  localparam logic [SumW-1:0] AccOffset = SumW'(2048 * SAMPLES_AVERAGED);
  localparam logic [CntW-1:0] LastCount = CntW'(SAMPLES_AVERAGED - 1);

  logic [SumW-1:0] x_sum_q, x_sum_d, y_sum_q, y_sum_d;
  logic [CntW-1:0] count_q, count_d;
  logic signed [11:0] x_shift, y_shift;
  logic [SumW-1:0] x_next, y_next;
  logic accept, used, last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign used       = accept && ((in_data_i.status_byte & STATUS_VALID_MASK) == STATUS_VALID_MASK);
  assign last       = (count_q == LastCount);

  assign x_shift = 12'(in_data_i.x_raw >>> 4);
  assign y_shift = 12'(in_data_i.y_raw >>> 4);
  assign x_next  = x_sum_q + {{(SumW - 12){x_shift[11]}}, x_shift};
  assign y_next  = y_sum_q + {{(SumW - 12){y_shift[11]}}, y_shift};

  assign push_o  = used && last;
  assign x_sum_o = x_next;
  assign y_sum_o = y_next;

  always_comb begin
    x_sum_d = x_sum_q;
    y_sum_d = y_sum_q;
    count_d = count_q;
    if (used) begin
      if (last) begin
        x_sum_d = AccOffset;
        y_sum_d = AccOffset;
        count_d = '0;
      end else begin
        x_sum_d = x_next;
        y_sum_d = y_next;
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q <= AccOffset;
      y_sum_q <= AccOffset;
      count_q <= '0;
    end else begin
      x_sum_q <= x_sum_d;
      y_sum_q <= y_sum_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: design/tsdc_queue.sv
`timescale 1ns / 1ps

module tsdc_queue import tsdc_pkg::*; #(
  parameter int unsigned Width = 2 * (12 + $clog2(SAMPLES_AVERAGED_DEF))
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] head_o
);

  // Two entries: one finished pair of sums can wait while the next is built.
  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: design/tsdc_back.sv
`timescale 1ns / 1ps

module tsdc_back import tsdc_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF,
  localparam int unsigned SumW = 12 + $clog2(SAMPLES_AVERAGED)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sums_valid_i,
  input  logic [SumW-1:0] x_sum_i,
  input  logic [SumW-1:0] y_sum_i,
  output logic            sums_pop_o,
  input  gain_cfg_t       gains_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  localparam int unsigned ProdW = 2 * SumW;
  // Reciprocal rounded down; the quotient comes out exact or one low.
  localparam logic [SumW-1:0] Recip   = SumW'((1 << SumW) / SAMPLES_AVERAGED);
  localparam logic [SumW-1:0] Divisor = SumW'(SAMPLES_AVERAGED);
  localparam logic [11:0]     AvgBias = 12'h800;

  localparam logic signed [18:0] NeutralS  = 19'(PULSE_NEUTRAL);
  localparam logic signed [18:0] SteerLoS  = 19'(STEER_LEFT);
  localparam logic signed [18:0] SteerHiS  = 19'(STEER_RIGHT);
  localparam logic signed [20:0] NeutralD  = 21'(PULSE_NEUTRAL);
  localparam logic signed [20:0] DriveLoS  = 21'(DRIVE_MIN);
  localparam logic signed [20:0] DriveHiS  = 21'(DRIVE_MAX);

  // Quotient correction and removal of the offset added by the front end.
  function automatic logic signed [11:0] finish_avg(logic [ProdW-1:0] prod,
                                                    logic [SumW-1:0] soff);
    logic [11:0]     q;
    logic [SumW-1:0] rem;
    q   = prod[SumW +: 12];
    rem = soff - SumW'(q) * Divisor;
    if (rem >= Divisor) begin
      q = q + 12'd1;
    end
    return signed'(q ^ AvgBias);
  endfunction

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic va_q, vb_q, vc_q, vd_q;

  logic [SumW-1:0]  sxa_q, sya_q;
  logic [ProdW-1:0] pxa_q, pya_q;

  logic signed [11:0] xb_q, yb_q;

  logic signed [11:0] xc_q, yc_q;
  logic signed [16:0] ps_q;
  logic signed [18:0] py_q;
  logic [17:0]        pr_q;
  logic [11:0]        abs_xb;

  logic signed [18:0] servo_raw;
  logic signed [20:0] drive_raw;
  out_item_t          out_q, out_d;

  assign rdy_d      = !vd_q || !out_stall_i;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign sums_pop_o = sums_valid_i && rdy_a;

  assign abs_xb = xb_q[11] ? 12'(-xb_q) : 12'(xb_q);

  always_comb begin
    servo_raw = NeutralS - 19'(ps_q);
    drive_raw = NeutralD + 21'(py_q) + 21'(signed'({1'b0, pr_q}));

    out_d.x_average = xc_q;
    out_d.y_average = yc_q;
    if (servo_raw < SteerLoS) begin
      out_d.servo_pulse = 12'(SteerLoS);
    end else if (servo_raw > SteerHiS) begin
      out_d.servo_pulse = 12'(SteerHiS);
    end else begin
      out_d.servo_pulse = 12'(servo_raw);
    end

    if (drive_raw > NeutralD) begin
      out_d.direction   = DIR_FORWARD;
      out_d.drive_pulse = (drive_raw > DriveHiS) ? 12'(DriveHiS) : 12'(drive_raw);
    end else if (drive_raw < NeutralD) begin
      out_d.direction   = DIR_REVERSE;
      out_d.drive_pulse = (drive_raw < DriveLoS) ? 12'(DriveLoS) : 12'(drive_raw);
    end else begin
      out_d.direction   = DIR_STOPPED;
      out_d.drive_pulse = 12'(NeutralD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && sums_valid_i) begin
      sxa_q <= x_sum_i;
      sya_q <= y_sum_i;
      pxa_q <= ProdW'(x_sum_i) * ProdW'(Recip);
      pya_q <= ProdW'(y_sum_i) * ProdW'(Recip);
    end
    if (rdy_b && va_q) begin
      xb_q <= finish_avg(pxa_q, sxa_q);
      yb_q <= finish_avg(pya_q, sya_q);
    end
    if (rdy_c && vb_q) begin
      xc_q <= xb_q;
      yc_q <= yb_q;
      ps_q <= 17'(signed'({1'b0, gains_i.steer_gain})) * 17'(xb_q);
      py_q <= 19'(signed'({1'b0, gains_i.pitch_speed_gain})) * 19'(yb_q);
      pr_q <= 18'(gains_i.roll_speed_gain) * 18'(abs_xb);
    end
    if (rdy_d && vc_q) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= sums_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  assign out_valid_o = vd_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/tilt_steer_drive_controller.sv
// Tilt-steered drive controller.
// Input channel (in_valid_i / in_stall_o / in_data_i): one accelerometer
// reading per transaction. Readings whose two data-ready status bits are
// not both set are taken and dropped. Every SAMPLES_AVERAGED used readings
// give one transaction on the output channel (out_valid_o / out_stall_i /
// out_data_o) carrying both averages, the clamped servo pulse, the saturated
// drive pulse and a direction code.
// Throughput: one reading per cycle while the queue is not full. The front
// end accumulates each reading into registered sums and hands each finished
// pair of sums to a two-entry queue; the back end is a four-stage pipeline
// (reciprocal multiply, quotient correction, gain multiplies, clamp and
// output register) that each pair enters from the queue.
// A stalled output holds its transaction and backs up the pipeline; the
// input stalls only once the queue is full as well.
// Gains are written over the configuration channel (always ready); the user
// writes them only while the block is idle, which the block does not enforce.
// Reset presets the sums to their offset, clears the count, the queue and
// the pipeline, and sets all three gains to one.
`timescale 1ns / 1ps

module tilt_steer_drive_controller import tsdc_pkg::*; #(
  parameter int unsigned SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned SumW = 12 + $clog2(SAMPLES_AVERAGED);

  gain_cfg_t gains_q;

  logic            q_push, q_full, q_valid, q_pop;
  logic [SumW-1:0] f_x_sum, f_y_sum, h_x_sum, h_y_sum;

  // Configuration writes are registered; an unknown index is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.steer_gain       <= 4'd1;
      gains_q.roll_speed_gain  <= 6'd1;
      gains_q.pitch_speed_gain <= 6'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STEER_GAIN:       gains_q.steer_gain       <= cfg_data_i[3:0];
        CFG_ROLL_SPEED_GAIN:  gains_q.roll_speed_gain  <= cfg_data_i[5:0];
        CFG_PITCH_SPEED_GAIN: gains_q.pitch_speed_gain <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Front end: qualifies readings and keeps the running sums.
  tsdc_front #(
    .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .x_sum_o    (f_x_sum),
    .y_sum_o    (f_y_sum)
  );

  // Queue of finished sum pairs between the two halves.
  tsdc_queue #(
    .Width(2 * SumW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({f_x_sum, f_y_sum}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      ({h_x_sum, h_y_sum})
  );

  // Back end: averaging divide, gains, clamping and the output register.
  tsdc_back #(
    .SAMPLES_AVERAGED(SAMPLES_AVERAGED)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sums_valid_i (q_valid),
    .x_sum_i      (h_x_sum),
    .y_sum_i      (h_y_sum),
    .sums_pop_o   (q_pop),
    .gains_i      (gains_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  a_servo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.servo_pulse >= 12'(STEER_LEFT) &&
                     out_data_o.servo_pulse <= 12'(STEER_RIGHT)))
    else $error("servo pulse outside the steering limits");

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.drive_pulse >= 12'(DRIVE_MIN) &&
                     out_data_o.drive_pulse <= 12'(DRIVE_MAX)))
    else $error("drive pulse outside the saturation limits");

  a_stop_is_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.direction == DIR_STOPPED) |->
      out_data_o.drive_pulse == 12'(PULSE_NEUTRAL))
    else $error("stopped direction with a non-neutral drive pulse");

  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("sum pair pushed into a full queue");
`endif

endmodule
